// File: src/thp_pkg.sv
`default_nettype none
package thp_pkg;

  localparam int unsigned FRONT_STAGES = 14;
  localparam int unsigned DIV_STAGES   = 32;
  localparam int unsigned POST_STAGES  = 4;
  localparam int unsigned CFG_W        = 48;
  localparam int unsigned CFG_IDX_W    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP_CAL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_A   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_B   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_C   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_A     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_B     = 3'd5;

  localparam logic [31:0] T_FINE_OFFSET = 32'd64000;
  localparam logic [31:0] P_BASE        = 32'd1048576;
  localparam logic [31:0] P_SCALE       = 32'd3125;
  localparam logic [31:0] P_HALF        = 32'd32768;
  localparam logic [31:0] H_OFFSET      = 32'd16384;
  localparam logic [31:0] H_SCALE       = 32'd1000;
  localparam logic [31:0] RECIP_100     = 32'd1374389535;
  localparam int unsigned RECIP_SHIFT   = 37;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } thp_in_t;

  typedef struct packed {
    logic [31:0] temperature_centi;
    logic [31:0] pressure_pascal;
    logic [31:0] humidity_milli;
    logic        divide_fault;
  } thp_out_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [7:0]  t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [7:0]  p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [7:0]  p6;
    logic [7:0]  p7;
    logic [15:0] p8;
    logic [15:0] p9;
    logic [7:0]  p10;
    logic [11:0] h1;
    logic [11:0] h2;
    logic [7:0]  h3;
    logic [7:0]  h4;
    logic [7:0]  h5;
    logic [7:0]  h6;
    logic [7:0]  h7;
  } thp_coef_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] hum;
    logic        fault;
    logic        hi;
  } thp_tag_t;

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    thp_tag_t    tag;
  } thp_div_req_t;

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b);
    return p[31:0];
  endfunction

  function automatic logic [31:0] sra32(input logic [31:0] a, input int unsigned n);
    return 32'($signed(a) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] x);
    return 32'($signed(x));
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] x);
    return 32'($signed(x));
  endfunction

  // Signed division by 100 truncating toward zero, by reciprocal multiplication.
  function automatic logic [31:0] div100(input logic [31:0] x);
    logic [31:0] mag;
    logic [63:0] p;
    logic [31:0] q;
    mag = x[31] ? (32'd0 - x) : x;
    p   = 64'(mag) * 64'(RECIP_100);
    q   = 32'(p >> RECIP_SHIFT);
    return x[31] ? (32'd0 - q) : q;
  endfunction

endpackage
`default_nettype wire

// File: src/thp_front.sv
`default_nettype none
module thp_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire thp_pkg::thp_in_t      data_i,
  input  wire thp_pkg::thp_coef_t    coef_i,
  output logic                       valid_o,
  output thp_pkg::thp_div_req_t      req_o
);
  import thp_pkg::*;

  logic [FRONT_STAGES-1:0] vld_q;

  logic [18:0] at1_d, at1_q;
  logic [17:0] ah;
  logic [34:0] pb2_d, pb2_q;
  logic [35:0] sqa2_d, sqa2_q;
  logic [23:0] sq12;
  logic [23:0] b3_d, b3_q;
  logic [35:0] c3_d, c3_q;
  logic [31:0] tf4_d, tf4_q;
  logic [35:0] t5x;
  logic [31:0] temp5_d, pa5_d, pa5_q;
  logic [31:0] q6;
  logic [31:0] sq6_d, sq6_q, m5_6_d, m2_6_d;
  logic [31:0] hm3_d, hm3_q, hm4_d, hm4_q, hm5_d, hm5_q, hm7_d, hm7_q;
  logic [31:0] x6_d, x6_q, x3_d, x3_q, ha7_d, d4_7_d, d5_d, d5_q, d7_d, d7_q;
  logic [31:0] bt8, at8;
  logic [31:0] pb8_d, pb8_q, pa8_d, pa8_q, x8_d, x8_q, v4_8_d;
  logic [31:0] am9_d, am9_q, pc9_d, pc9_q, hb9_d, hb9_q;
  logic [31:0] dv10_d, num10_d, hbm10_d, hbm10_q;
  logic        hi10_d;
  logic [31:0] c11_d, c14, s5_d, s5_q, v6m_d, v6m_q, hm14_d, hm14_q;

  logic [31:0] m5_q [6:7];
  logic [31:0] m2_q [6:7];
  logic [19:0] padc_q [1:8];
  logic [15:0] hadc_q [1:6];
  logic [31:0] temp_q [5:14];
  logic [31:0] ha_q [7:10];
  logic [31:0] d4_q [7:8];
  logic [31:0] v4_q [8:12];
  logic [31:0] c_q [11:13];
  logic [31:0] dv_q [10:14];
  logic [31:0] num_q [10:14];
  logic        hi_q [10:14];

  always_comb begin
    at1_d  = 19'({2'b00, data_i.raw_temperature[19:3]}) - 19'({2'b00, coef_i.t1, 1'b0});
    ah     = 18'($signed(at1_q) >>> 1);
    pb2_d  = 35'($signed(at1_q)) * 35'($signed(coef_i.t2));
    sqa2_d = 36'($signed(ah)) * 36'($signed(ah));
    sq12   = 24'($signed(sqa2_q) >>> 12);
    b3_d   = 24'($signed(pb2_q) >>> 11);
    c3_d   = 36'($signed(sq12)) * 36'($signed({coef_i.t3, 4'b0000}));
    tf4_d  = 32'($signed(b3_q)) + 32'($signed(c3_q) >>> 14);
    t5x    = 36'($signed(tf4_q)) * 36'sd5 + 36'sd128;
    temp5_d = 32'($signed(t5x) >>> 8);
    pa5_d  = sra32(tf4_q, 1) - T_FINE_OFFSET;

    q6     = sra32(pa5_q, 2);
    sq6_d  = mul32(q6, q6);
    m5_6_d = mul32(pa5_q, sx16(coef_i.p5));
    m2_6_d = mul32(sx16(coef_i.p2), pa5_q);
    hm3_d  = mul32(temp_q[5], sx8(coef_i.h3));
    hm4_d  = mul32(temp_q[5], sx8(coef_i.h4));
    hm5_d  = mul32(temp_q[5], sx8(coef_i.h5));
    hm7_d  = mul32(temp_q[5], sx8(coef_i.h7));

    x6_d   = mul32(sra32(sq6_q, 11), sx8(coef_i.p6));
    x3_d   = mul32(sra32(sq6_q, 13), sx8(coef_i.p3) << 5);
    ha7_d  = {16'd0, hadc_q[6]} - ({20'd0, coef_i.h1} << 4) - sra32(div100(hm3_q), 1);
    d4_7_d = div100(hm4_q);
    d5_d   = div100(hm5_q);
    d7_d   = div100(hm7_q);

    bt8    = sra32(x6_q, 2) + (m5_q[7] << 1);
    pb8_d  = sra32(bt8, 2) + (sx16(coef_i.p4) << 16);
    at8    = sra32(x3_q, 3) + sra32(m2_q[7], 1);
    pa8_d  = sra32(at8, 18) + P_HALF;
    x8_d   = mul32(temp_q[7], d5_q);
    v4_8_d = sra32(({24'd0, coef_i.h6} << 7) + d7_q, 4);

    am9_d  = mul32(pa8_q, {16'd0, coef_i.p1});
    pc9_d  = mul32(P_BASE - {12'd0, padc_q[8]} - sra32(pb8_q, 12), P_SCALE);
    hb9_d  = d4_q[8] + div100(sra32(x8_q, 6)) + H_OFFSET;

    dv10_d  = sra32(am9_q, 15);
    hi10_d  = !pc9_q[31] && pc9_q[30];
    num10_d = hi10_d ? pc9_q : (pc9_q << 1);
    hbm10_d = mul32({20'd0, coef_i.h2}, hb9_q);

    c11_d  = mul32(ha_q[10], sra32(hbm10_q, 10));
    c14    = sra32(c_q[11], 14);
    s5_d   = mul32(c14, c14);
    v6m_d  = mul32(v4_q[12], sra32(s5_q, 10));
    hm14_d = mul32(sra32(c_q[13] + sra32(v6m_q, 1), 10), H_SCALE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[FRONT_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      at1_q     <= at1_d;
      padc_q[1] <= data_i.raw_pressure;
      hadc_q[1] <= data_i.raw_humidity;
      for (int k = 2; k <= 8; k++) padc_q[k] <= padc_q[k-1];
      for (int k = 2; k <= 6; k++) hadc_q[k] <= hadc_q[k-1];
      pb2_q     <= pb2_d;
      sqa2_q    <= sqa2_d;
      b3_q      <= b3_d;
      c3_q      <= c3_d;
      tf4_q     <= tf4_d;
      temp_q[5] <= temp5_d;
      for (int k = 6; k <= 14; k++) temp_q[k] <= temp_q[k-1];
      pa5_q     <= pa5_d;
      sq6_q     <= sq6_d;
      m5_q[6]   <= m5_6_d;
      m5_q[7]   <= m5_q[6];
      m2_q[6]   <= m2_6_d;
      m2_q[7]   <= m2_q[6];
      hm3_q     <= hm3_d;
      hm4_q     <= hm4_d;
      hm5_q     <= hm5_d;
      hm7_q     <= hm7_d;
      x6_q      <= x6_d;
      x3_q      <= x3_d;
      ha_q[7]   <= ha7_d;
      for (int k = 8; k <= 10; k++) ha_q[k] <= ha_q[k-1];
      d4_q[7]   <= d4_7_d;
      d4_q[8]   <= d4_q[7];
      d5_q      <= d5_d;
      d7_q      <= d7_d;
      pb8_q     <= pb8_d;
      pa8_q     <= pa8_d;
      x8_q      <= x8_d;
      v4_q[8]   <= v4_8_d;
      for (int k = 9; k <= 12; k++) v4_q[k] <= v4_q[k-1];
      am9_q     <= am9_d;
      pc9_q     <= pc9_d;
      hb9_q     <= hb9_d;
      dv_q[10]  <= dv10_d;
      num_q[10] <= num10_d;
      hi_q[10]  <= hi10_d;
      for (int k = 11; k <= 14; k++) begin
        dv_q[k]  <= dv_q[k-1];
        num_q[k] <= num_q[k-1];
        hi_q[k]  <= hi_q[k-1];
      end
      hbm10_q   <= hbm10_d;
      c_q[11]   <= c11_d;
      c_q[12]   <= c_q[11];
      c_q[13]   <= c_q[12];
      s5_q      <= s5_d;
      v6m_q     <= v6m_d;
      hm14_q    <= hm14_d;
    end
  end

  assign valid_o       = vld_q[FRONT_STAGES-1];
  assign req_o.num     = num_q[14];
  assign req_o.den     = dv_q[14];
  assign req_o.tag.temp  = temp_q[14];
  assign req_o.tag.hum   = hm14_q;
  assign req_o.tag.fault = (dv_q[14] == 32'd0);
  assign req_o.tag.hi    = hi_q[14];

endmodule
`default_nettype wire

// File: src/thp_div.sv
`default_nettype none
module thp_div (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire thp_pkg::thp_div_req_t req_i,
  output logic                       valid_o,
  output logic [31:0]                quo_o,
  output thp_pkg::thp_tag_t          tag_o
);
  import thp_pkg::*;

  logic [DIV_STAGES-1:0] vld_q;
  logic [31:0] rem_d [DIV_STAGES];
  logic [31:0] rem_q [DIV_STAGES];
  logic [31:0] quo_d [DIV_STAGES];
  logic [31:0] quo_q [DIV_STAGES];
  logic [31:0] den_d [DIV_STAGES];
  logic [31:0] den_q [DIV_STAGES];
  thp_tag_t    tag_q [DIV_STAGES];
  logic [31:0] rin, nin, din;
  logic [33:0] trial;

  always_comb begin
    rin   = '0;
    nin   = '0;
    din   = '0;
    trial = '0;
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        rin = '0;
        nin = req_i.num;
        din = req_i.den;
      end else begin
        rin = rem_q[k-1];
        nin = quo_q[k-1];
        din = den_q[k-1];
      end
      trial = {1'b0, rin, nin[31]} - {2'b00, din};
      if (!trial[33]) begin
        rem_d[k] = trial[31:0];
        quo_d[k] = {nin[30:0], 1'b1};
      end else begin
        rem_d[k] = {rin[30:0], nin[31]};
        quo_d[k] = {nin[30:0], 1'b0};
      end
      den_d[k] = din;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DIV_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
        den_q[k] <= den_d[k];
      end
      tag_q[0] <= req_i.tag;
      for (int k = 1; k < DIV_STAGES; k++) tag_q[k] <= tag_q[k-1];
    end
  end

  assign valid_o = vld_q[DIV_STAGES-1];
  assign quo_o   = quo_q[DIV_STAGES-1];
  assign tag_o   = tag_q[DIV_STAGES-1];

endmodule
`default_nettype wire

// File: src/thp_post.sv
`default_nettype none
module thp_post (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire logic [31:0]         quo_i,
  input  wire thp_pkg::thp_tag_t   tag_i,
  input  wire thp_pkg::thp_coef_t  coef_i,
  output logic                     valid_o,
  output thp_pkg::thp_out_t        data_o
);
  import thp_pkg::*;

  logic [POST_STAGES-1:0] vld_q;
  logic [31:0] uq, r1;
  logic [31:0] qq1_d, m8_1_d, rr1_d, a2_d, rrr2_d, cm3_d;
  logic [31:0] pc1_q, qq1_q, m8_1_q, r1_q, rr1_q;
  logic [31:0] pc2_q, a2_q, rrr2_q, m8_2_q;
  logic [31:0] pc3_q, a3_q, cm3_q, b3_q;
  logic [31:0] sum;
  thp_tag_t    tag1_q, tag2_q, tag3_q;
  thp_out_t    out_d, out_q;

  always_comb begin
    uq     = tag_i.hi ? {quo_i[30:0], 1'b0} : quo_i;
    r1     = sra32(uq, 8);
    qq1_d  = mul32(sra32(uq, 3), sra32(uq, 3));
    m8_1_d = mul32(sra32(uq, 2), sx16(coef_i.p8));
    rr1_d  = mul32(r1, r1);
    a2_d   = mul32(sx16(coef_i.p9), sra32(qq1_q, 13));
    rrr2_d = mul32(rr1_q, r1_q);
    cm3_d  = mul32(rrr2_q, {24'd0, coef_i.p10});
    sum    = a3_q + b3_q + sra32(cm3_q, 17) + (sx8(coef_i.p7) << 7);
    out_d.temperature_centi = tag3_q.temp;
    out_d.pressure_pascal   = tag3_q.fault ? 32'd0 : (pc3_q + sra32(sum, 4));
    out_d.humidity_milli    = sra32(tag3_q.hum, 12);
    out_d.divide_fault      = tag3_q.fault;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[POST_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pc1_q  <= uq;
      qq1_q  <= qq1_d;
      m8_1_q <= m8_1_d;
      r1_q   <= r1;
      rr1_q  <= rr1_d;
      tag1_q <= tag_i;
      pc2_q  <= pc1_q;
      a2_q   <= a2_d;
      rrr2_q <= rrr2_d;
      m8_2_q <= m8_1_q;
      tag2_q <= tag1_q;
      pc3_q  <= pc2_q;
      a3_q   <= sra32(a2_q, 12);
      cm3_q  <= cm3_d;
      b3_q   <= sra32(m8_2_q, 13);
      tag3_q <= tag2_q;
      out_q  <= out_d;
    end
  end

  assign valid_o = vld_q[POST_STAGES-1];
  assign data_o  = out_q;

endmodule
`default_nettype wire

// File: src/thp_sensor_compensation_unit.sv
// Fully pipelined: one reading triple per cycle unless the output stalls; a reading passes
// through 14 front stages, a 32-stage one-bit-per-stage divider and 4 back stages.
// The whole pipeline advances when the output register is empty or being taken.
// Reset clears all valid bits and the six calibration registers to zero.
`default_nettype none
module thp_sensor_compensation_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_write_en_i,
  input  wire logic [thp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [thp_pkg::CFG_W-1:0]        cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire thp_pkg::thp_in_t                 in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output thp_pkg::thp_out_t                     out_data_o
);
  import thp_pkg::*;

  logic [39:0] temp_cal_q, press_a_q, press_c_q, hum_b_q;
  logic [47:0] press_b_q;
  logic [23:0] hum_a_q;
  thp_coef_t    coef;
  logic         en;
  logic         front_valid, div_valid;
  thp_div_req_t div_req;
  logic [31:0]  quo;
  thp_tag_t     tag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_cal_q <= '0;
      press_a_q  <= '0;
      press_b_q  <= '0;
      press_c_q  <= '0;
      hum_a_q    <= '0;
      hum_b_q    <= '0;
    end else if (cfg_write_en_i) begin
      unique case (cfg_index_i)
        REG_TEMP_CAL: temp_cal_q <= cfg_data_i[39:0];
        REG_PRESS_A:  press_a_q  <= cfg_data_i[39:0];
        REG_PRESS_B:  press_b_q  <= cfg_data_i;
        REG_PRESS_C:  press_c_q  <= cfg_data_i[39:0];
        REG_HUM_A:    hum_a_q    <= cfg_data_i[23:0];
        REG_HUM_B:    hum_b_q    <= cfg_data_i[39:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    coef.t1  = temp_cal_q[15:0];
    coef.t2  = temp_cal_q[31:16];
    coef.t3  = temp_cal_q[39:32];
    coef.p1  = press_a_q[15:0];
    coef.p2  = press_a_q[31:16];
    coef.p3  = press_a_q[39:32];
    coef.p4  = press_b_q[15:0];
    coef.p5  = press_b_q[31:16];
    coef.p6  = press_b_q[39:32];
    coef.p7  = press_b_q[47:40];
    coef.p8  = press_c_q[15:0];
    coef.p9  = press_c_q[31:16];
    coef.p10 = press_c_q[39:32];
    coef.h1  = hum_a_q[11:0];
    coef.h2  = hum_a_q[23:12];
    coef.h3  = hum_b_q[7:0];
    coef.h4  = hum_b_q[15:8];
    coef.h5  = hum_b_q[23:16];
    coef.h6  = hum_b_q[31:24];
    coef.h7  = hum_b_q[39:32];
  end

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  thp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .coef_i  (coef),
    .valid_o (front_valid),
    .req_o   (div_req)
  );

  thp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_valid),
    .req_i   (div_req),
    .valid_o (div_valid),
    .quo_o   (quo),
    .tag_o   (tag)
  );

  thp_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_valid),
    .quo_i   (quo),
    .tag_i   (tag),
    .coef_i  (coef),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import thp_pkg::*;

  localparam int unsigned NUM_CAL      = 6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int unsigned PIPE_DEPTH   = FRONT_STAGES + DIV_STAGES + POST_STAGES;
  localparam int unsigned STALL_LIMIT  = 5000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_write_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  thp_in_t              in_data;
  logic                 out_valid;
  logic                 out_ready;
  thp_out_t             out_data;

  logic [CFG_W-1:0] cal_shadow [NUM_CAL];
  thp_out_t         pending_readings [$];
  int unsigned      mismatch_count;
  int unsigned      quiet_cycles;
  int unsigned      sender_idle_pct;
  int unsigned      receiver_stall_pct;
  int unsigned      hold_cycles;

  thp_sensor_compensation_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_write_en_i(cfg_write_en),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .in_data_i     (in_data),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_o    (out_data)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic longint wrap32(longint x);
    return longint'(int'(x));
  endfunction

  function automatic longint mul32w(longint a, longint b);
    return wrap32(a * b);
  endfunction

  function automatic longint shl32w(longint a, int n);
    return wrap32(a <<< n);
  endfunction

  function automatic thp_out_t compensate_reading(thp_in_t r);
    longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10;
    longint h1, h2, h3, h4, h5, h6, h7;
    longint a, b, c, q, sq, tf, temp, pc, hum;
    int unsigned dv, uq;
    thp_out_t res;
    t1 = longint'(cal_shadow[REG_TEMP_CAL][15:0]);
    t2 = longint'($signed(cal_shadow[REG_TEMP_CAL][31:16]));
    t3 = longint'($signed(cal_shadow[REG_TEMP_CAL][39:32]));
    p1 = longint'(cal_shadow[REG_PRESS_A][15:0]);
    p2 = longint'($signed(cal_shadow[REG_PRESS_A][31:16]));
    p3 = longint'($signed(cal_shadow[REG_PRESS_A][39:32]));
    p4 = longint'($signed(cal_shadow[REG_PRESS_B][15:0]));
    p5 = longint'($signed(cal_shadow[REG_PRESS_B][31:16]));
    p6 = longint'($signed(cal_shadow[REG_PRESS_B][39:32]));
    p7 = longint'($signed(cal_shadow[REG_PRESS_B][47:40]));
    p8 = longint'($signed(cal_shadow[REG_PRESS_C][15:0]));
    p9 = longint'($signed(cal_shadow[REG_PRESS_C][31:16]));
    p10 = longint'(cal_shadow[REG_PRESS_C][39:32]);
    h1 = longint'(cal_shadow[REG_HUM_A][11:0]);
    h2 = longint'(cal_shadow[REG_HUM_A][23:12]);
    h3 = longint'($signed(cal_shadow[REG_HUM_B][7:0]));
    h4 = longint'($signed(cal_shadow[REG_HUM_B][15:8]));
    h5 = longint'($signed(cal_shadow[REG_HUM_B][23:16]));
    h6 = longint'(cal_shadow[REG_HUM_B][31:24]);
    h7 = longint'($signed(cal_shadow[REG_HUM_B][39:32]));

    a = (longint'(r.raw_temperature) >>> 3) - t1 * 2;
    b = (a * t2) >>> 11;
    c = ((((a >>> 1) * (a >>> 1)) >>> 12) * (t3 * 16)) >>> 14;
    tf = wrap32(b + c);
    temp = wrap32((tf * 5 + 128) >>> 8);

    a = wrap32((tf >>> 1) - 64000);
    q = a >>> 2;
    sq = mul32w(q, q);
    b = mul32w(sq >>> 11, p6) >>> 2;
    b = wrap32(b + shl32w(mul32w(a, p5), 1));
    b = wrap32((b >>> 2) + shl32w(p4, 16));
    a = wrap32((mul32w(sq >>> 13, shl32w(p3, 5)) >>> 3) + (mul32w(p2, a) >>> 1));
    a = a >>> 18;
    a = mul32w(wrap32(32768 + a), p1) >>> 15;
    pc = wrap32(1048576 - longint'(r.raw_pressure));
    pc = mul32w(wrap32(pc - (b >>> 12)), 3125);
    dv = 32'(a);
    res.divide_fault = (dv == 0);
    if (res.divide_fault) begin
      pc = 0;
    end else begin
      if (pc >= (longint'(1) <<< 30)) begin
        uq = (32'(pc) / dv) << 1;
      end else begin
        uq = 32'(shl32w(pc, 1)) / dv;
      end
      pc = wrap32(longint'(uq));
      q = pc >>> 3;
      a = mul32w(p9, mul32w(q, q) >>> 13) >>> 12;
      b = mul32w(pc >>> 2, p8) >>> 13;
      q = pc >>> 8;
      c = mul32w(mul32w(mul32w(q, q), q), p10) >>> 17;
      pc = wrap32(pc + (wrap32(a + b + c + shl32w(p7, 7)) >>> 4));
    end

    a = wrap32(longint'(r.raw_humidity) - shl32w(h1, 4) - (mul32w(temp, h3) / 100 >>> 1));
    b = wrap32(mul32w(temp, h4) / 100
               + ((mul32w(temp, mul32w(temp, h5) / 100) >>> 6) / 100) + 16384);
    b = mul32w(h2, b) >>> 10;
    c = mul32w(a, b);
    q = wrap32(shl32w(h6, 7) + mul32w(temp, h7) / 100) >>> 4;
    sq = mul32w(c >>> 14, c >>> 14) >>> 10;
    sq = mul32w(q, sq) >>> 1;
    hum = mul32w(wrap32(c + sq) >>> 10, 1000) >>> 12;

    res.temperature_centi = 32'(temp);
    res.pressure_pascal   = 32'(pc);
    res.humidity_milli    = 32'(hum);
    return res;
  endfunction

  always @(posedge clk_i) begin
    thp_out_t exp_res;
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write_en) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, nothing transferred for %0d cycles", $time, quiet_cycles);
        $display("Mismatches found");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (pending_readings.size() == 0) begin
          $display("%0t: unexpected transfer, actual %h", $time, out_data);
          mismatch_count++;
        end else begin
          exp_res = pending_readings.pop_front();
          if (out_data.temperature_centi !== exp_res.temperature_centi) begin
            $display("%0t: temperature expected %0d actual %0d", $time,
                     $signed(exp_res.temperature_centi), $signed(out_data.temperature_centi));
            mismatch_count++;
          end
          if (out_data.pressure_pascal !== exp_res.pressure_pascal) begin
            $display("%0t: pressure expected %0d actual %0d", $time,
                     $signed(exp_res.pressure_pascal), $signed(out_data.pressure_pascal));
            mismatch_count++;
          end
          if (out_data.humidity_milli !== exp_res.humidity_milli) begin
            $display("%0t: humidity expected %0d actual %0d", $time,
                     $signed(exp_res.humidity_milli), $signed(out_data.humidity_milli));
            mismatch_count++;
          end
          if (out_data.divide_fault !== exp_res.divide_fault) begin
            $display("%0t: divide fault expected %b actual %b", $time,
                     exp_res.divide_fault, out_data.divide_fault);
            mismatch_count++;
          end
        end
      end
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles <= hold_cycles - 1;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  task automatic send_reading(input thp_in_t r);
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk_i); while (!in_ready);
    pending_readings.push_back(compensate_reading(r));
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 10) @(posedge clk_i);
  endtask

  // All six calibration registers are written, then one write to an unused index
  // that the block must ignore.
  task automatic load_calibration(input logic [CFG_W-1:0] vals [NUM_CAL]);
    for (int i = 0; i < NUM_CAL; i++) begin
      cfg_write_en <= 1'b1;
      cfg_index    <= CFG_IDX_W'(i);
      cfg_data     <= vals[i];
      @(posedge clk_i);
      cal_shadow[i] = vals[i];
    end
    cfg_index <= REG_UNUSED;
    cfg_data  <= CFG_W'({$urandom, $urandom});
    @(posedge clk_i);
    cfg_write_en <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic thp_in_t random_reading();
    thp_in_t r;
    r.raw_temperature = 20'($urandom);
    r.raw_pressure    = 20'($urandom);
    r.raw_humidity    = 16'($urandom);
    return r;
  endfunction

  task automatic load_random_calibration();
    logic [CFG_W-1:0] vals [NUM_CAL];
    for (int i = 0; i < NUM_CAL; i++) vals[i] = CFG_W'({$urandom, $urandom});
    load_calibration(vals);
  endtask

  task automatic test_directed();
    logic [CFG_W-1:0] vals [NUM_CAL];
    thp_in_t corner [5];
    corner[0] = '0;
    corner[1] = '1;
    corner[2] = '{raw_temperature: 20'd519888, raw_pressure: 20'd415148,
                  raw_humidity: 16'd30000};
    corner[3] = '{raw_temperature: 20'h80000, raw_pressure: 20'h80000, raw_humidity: 16'h8000};
    corner[4] = '{raw_temperature: 20'h7ffff, raw_pressure: 20'h00001, raw_humidity: 16'h7fff};
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    // Reset calibration: zero divisor, so pressure must come out as 0 with the fault flag.
    foreach (corner[i]) send_reading(corner[i]);
    wait_idle();
    vals[REG_TEMP_CAL] = CFG_W'({8'sd3, 16'd26435, 16'd27504});
    vals[REG_PRESS_A]  = CFG_W'({8'h00, 16'hd6d0, 16'd36477});
    vals[REG_PRESS_B]  = {8'd15, 8'hf9, 16'h0d47, 16'd2855};
    vals[REG_PRESS_C]  = CFG_W'({8'd30, 16'd4285, 16'hc0e4});
    vals[REG_HUM_A]    = CFG_W'({12'd1020, 12'd754});
    vals[REG_HUM_B]    = CFG_W'({8'd30, 8'd0, 8'd50, 8'hf0, 8'd88});
    load_calibration(vals);
    foreach (corner[i]) send_reading(corner[i]);
    wait_idle();
    for (int i = 0; i < NUM_CAL; i++) vals[i] = '1;
    load_calibration(vals);
    foreach (corner[i]) send_reading(corner[i]);
    wait_idle();
    for (int i = 0; i < NUM_CAL; i++) vals[i] = {1'b0, {(CFG_W-1){1'b1}}};
    vals[REG_TEMP_CAL] = CFG_W'({8'h80, 16'h8000, 16'hffff});
    vals[REG_PRESS_A]  = CFG_W'({8'h7f, 16'h7fff, 16'hffff});
    load_calibration(vals);
    foreach (corner[i]) send_reading(corner[i]);
    wait_idle();
  endtask

  task automatic test_random_phase(input int unsigned send_idle, input int unsigned recv_stall,
                                   input int unsigned count);
    sender_idle_pct = send_idle;
    receiver_stall_pct = recv_stall;
    for (int k = 0; k < count; k++) begin
      if (k % 25 == 0) begin
        wait_idle();
        load_random_calibration();
      end
      send_reading(random_reading());
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    load_random_calibration();
    hold_cycles = 300;
    for (int k = 0; k < 80; k++) send_reading(random_reading());
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_readings.size() != 0) @(posedge clk_i);
    for (int k = 0; k < 20; k++) send_reading(random_reading());
    wait_idle();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_write_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    mismatch_count = 0;
    quiet_cycles = 0;
    hold_cycles = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    for (int i = 0; i < NUM_CAL; i++) cal_shadow[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_phase(0, 0, 70);
    test_random_phase(75, 0, 70);
    test_random_phase(0, 75, 70);
    test_random_phase(12, 12, 70);
    test_backpressure();
    repeat (PIPE_DEPTH + 10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_readings.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
